>>> hdl/lba_chs_address_translator_unit_assert.svh
// Assertion macros shared by the checker of the LBA/CHS address translator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef LBA_CHS_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH
`define LBA_CHS_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCAT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lba_chs_pkg.sv
// Shared constants for the LBA/CHS address translator: field widths,
// operation codes, register indexes and geometry reset values. No dependencies.
`timescale 1ns / 1ps

package lba_chs_pkg;

    localparam int CYL_W     = 10;
    localparam int HEAD_W    = 8;
    localparam int SEC_W     = 6;
    localparam int CCNT_W    = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CHS_W     = CYL_W + HEAD_W + SEC_W;

    // Intermediate product widths: cyl*heads+head, then times sectors plus offset.
    localparam int PA_W   = CYL_W + HEAD_W + 1;
    localparam int PROD_W = PA_W + SEC_W + 1;
    localparam int TOT_W  = CCNT_W + HEAD_W + SEC_W;

    // Quotient bits resolved per divider stage.
    localparam int DIV_STEP = 4;

    localparam logic OP_LBA_TO_CHS = 1'b0;
    localparam logic OP_CHS_TO_LBA = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CYL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPT        = 2'd2;

    localparam logic [CCNT_W-1:0] RST_CYL_COUNT  = 11'd80;
    localparam logic [HEAD_W-1:0] RST_HEAD_COUNT = 8'd2;
    localparam logic [SEC_W-1:0]  RST_SPT        = 6'd18;

endpackage

>>> hdl/lba_chs_address_translator_unit.sv
// LBA/CHS address translator, pipelined. Depends on lba_chs_pkg.
// Converts linear sector numbers to cylinder/head/sector and back.
`timescale 1ns / 1ps

// The block accepts one item per clock while the output is not stalled and returns
// one result item per input item, in order. The pipeline is made of one input
// stage, two multiplier stages, two restoring dividers that each resolve four
// quotient bits per stage (LBA by sectors per track, then track by head count),
// and the output register. Every stage has its own valid bit and holds while the
// next one is full, so a stall at the output backs up without loss and bubbles
// are squeezed out. Geometry must be written through the register port only while
// no item is in flight; the block itself does not enforce this. A result with
// m_axis_tuser set (range error) carries all-zero address fields.
module lba_chs_address_translator_unit
    import lba_chs_pkg::*;
#(
    parameter int LBA_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, low bit up: linear_sector_in, cylinder_in, head_in, sector_in, zero fill.
    input  logic [((LBA_BITS+CHS_W+7)/8)*8-1:0] s_axis_tdata,
    // tuser: operation.
    input  logic                 s_axis_tuser,
    // Result item stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata, low bit up: linear_sector_out, cylinder_out, head_out, sector_out, zero fill.
    output logic [((LBA_BITS+CHS_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: range_error.
    output logic                 m_axis_tuser,
    // Geometry register write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int TDATA_W  = ((LBA_BITS + CHS_W + 7) / 8) * 8;
    localparam int DIV_ST   = (LBA_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD      = DIV_ST * DIV_STEP;
    localparam int DIV1_LO  = 3;
    localparam int DIV2_LO  = DIV1_LO + DIV_ST;
    localparam int NUM_WORK = DIV2_LO + DIV_ST;
    localparam int BIG_W    = (PAD > TOT_W) ? PAD : TOT_W;

    typedef struct packed {
        logic              op;
        logic [PAD-1:0]    acc;     // dividend, shifted out as quotient bits shift in
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] head;
        logic [SEC_W-1:0]  sec;
        logic              bad;
        logic [PROD_W-1:0] prod;
        logic [TOT_W-1:0]  tot;
        logic              beyond;
        logic [SEC_W-1:0]  rem1;
        logic [HEAD_W-1:0] rem2;
    } t_item;

    logic [CCNT_W-1:0] r_cyl_cnt;
    logic [HEAD_W-1:0] r_head_cnt;
    logic [SEC_W-1:0]  r_spt;

    logic [NUM_WORK-1:0] r_vld;
    logic [NUM_WORK-1:0] w_vin;
    logic [NUM_WORK-1:0] w_en;
    logic                w_en_out;
    t_item               r_st [NUM_WORK];
    t_item               n_st [NUM_WORK];

    logic                r_out_vld;
    logic [LBA_BITS-1:0] r_lba;
    logic [CYL_W-1:0]    r_cyl;
    logic [HEAD_W-1:0]   r_head;
    logic [SEC_W-1:0]    r_sec;
    logic                r_err;
    logic [LBA_BITS-1:0] n_lba;
    logic [CYL_W-1:0]    n_cyl;
    logic [HEAD_W-1:0]   n_head;
    logic [SEC_W-1:0]    n_sec;
    logic                n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyl_cnt  <= RST_CYL_COUNT;
            r_head_cnt <= RST_HEAD_COUNT;
            r_spt      <= RST_SPT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CYL_COUNT:  r_cyl_cnt  <= i_cfg_data[CCNT_W-1:0];
                REG_HEAD_COUNT: r_head_cnt <= i_cfg_data[HEAD_W-1:0];
                REG_SPT:        r_spt      <= i_cfg_data[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads too.
    always_comb begin
        w_en_out           = !r_out_vld || m_axis_tready;
        w_en[NUM_WORK-1]   = !r_vld[NUM_WORK-1] || w_en_out;
        for (int k = NUM_WORK - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        w_vin[0] = s_axis_tvalid;
        for (int k = 1; k < NUM_WORK; k++) begin
            w_vin[k] = r_vld[k-1];
        end
    end

    assign s_axis_tready = w_en[0];

    for (genvar k = 0; k < NUM_WORK; k++) begin : g_stage
        if (k == 0) begin : g_in
            always_comb begin
                t_item it;
                logic  zero_geom;
                logic  chs_bad;
                it        = '0;
                it.op     = s_axis_tuser;
                it.acc    = PAD'(s_axis_tdata[LBA_BITS-1:0]);
                it.cyl    = s_axis_tdata[LBA_BITS +: CYL_W];
                it.head   = s_axis_tdata[LBA_BITS+CYL_W +: HEAD_W];
                it.sec    = s_axis_tdata[LBA_BITS+CYL_W+HEAD_W +: SEC_W];
                zero_geom = (r_cyl_cnt == '0) || (r_head_cnt == '0) || (r_spt == '0);
                chs_bad   = (it.sec == '0) || (it.sec > r_spt) || (it.head >= r_head_cnt)
                            || ({1'b0, it.cyl} >= r_cyl_cnt);
                it.bad    = zero_geom || ((it.op == OP_CHS_TO_LBA) && chs_bad);
                n_st[k]   = it;
            end
        end else if (k == 1) begin : g_mul_a
            always_comb begin
                t_item it;
                it      = r_st[k-1];
                it.prod = PROD_W'(it.cyl) * PROD_W'(r_head_cnt) + PROD_W'(it.head);
                it.tot  = TOT_W'(r_cyl_cnt) * TOT_W'(r_head_cnt);
                n_st[k] = it;
            end
        end else if (k == 2) begin : g_mul_b
            always_comb begin
                t_item it;
                it      = r_st[k-1];
                it.prod = PROD_W'(it.prod[PA_W-1:0]) * PROD_W'(r_spt)
                          + PROD_W'(SEC_W'(it.sec - SEC_W'(1)));
                it.tot  = TOT_W'(it.tot[PA_W-1:0]) * TOT_W'(r_spt);
                n_st[k] = it;
            end
        end else if (k < DIV2_LO) begin : g_div_spt
            always_comb begin
                t_item            it;
                logic [SEC_W:0]   trial;
                logic [SEC_W-1:0] rem;
                it = r_st[k-1];
                // The first divider stage still sees the whole LBA.
                if (k == DIV1_LO) begin
                    it.beyond = BIG_W'(it.acc) >= BIG_W'(it.tot);
                end
                rem = it.rem1;
                for (int j = 0; j < DIV_STEP; j++) begin
                    trial  = {rem, it.acc[PAD-1]};
                    it.acc = {it.acc[PAD-2:0], 1'b0};
                    if (trial >= {1'b0, r_spt}) begin
                        trial     = trial - {1'b0, r_spt};
                        it.acc[0] = 1'b1;
                    end
                    rem = trial[SEC_W-1:0];
                end
                it.rem1 = rem;
                n_st[k] = it;
            end
        end else begin : g_div_head
            always_comb begin
                t_item             it;
                logic [HEAD_W:0]   trial;
                logic [HEAD_W-1:0] rem;
                it  = r_st[k-1];
                rem = it.rem2;
                for (int j = 0; j < DIV_STEP; j++) begin
                    trial  = {rem, it.acc[PAD-1]};
                    it.acc = {it.acc[PAD-2:0], 1'b0};
                    if (trial >= {1'b0, r_head_cnt}) begin
                        trial     = trial - {1'b0, r_head_cnt};
                        it.acc[0] = 1'b1;
                    end
                    rem = trial[HEAD_W-1:0];
                end
                it.rem2 = rem;
                n_st[k] = it;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_WORK; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_WORK; k++) begin
            if (w_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Final checks and field selection; the last divider leaves the cylinder in acc.
    always_comb begin
        t_item it;
        logic  cyl_over;
        logic  lba_ovf;
        it       = r_st[NUM_WORK-1];
        cyl_over = |it.acc[PAD-1:CYL_W];
        lba_ovf  = (it.prod >> LBA_BITS) != '0;
        n_err    = it.bad || ((it.op == OP_LBA_TO_CHS) ? (it.beyond || cyl_over) : lba_ovf);
        n_lba    = '0;
        n_cyl    = '0;
        n_head   = '0;
        n_sec    = '0;
        if (!n_err) begin
            if (it.op == OP_CHS_TO_LBA) begin
                n_lba = LBA_BITS'(it.prod);
            end else begin
                n_cyl  = it.acc[CYL_W-1:0];
                n_head = it.rem2;
                n_sec  = it.rem1 + SEC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en_out) begin
            r_out_vld <= r_vld[NUM_WORK-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_lba  <= n_lba;
            r_cyl  <= n_cyl;
            r_head <= n_head;
            r_sec  <= n_sec;
            r_err  <= n_err;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDATA_W'({r_sec, r_head, r_cyl, r_lba});
    assign m_axis_tuser  = r_err;

endmodule

>>> hdl/lba_chs_checker.sv
// Port-level checker for the LBA/CHS address translator, bound to the top level.
// Depends on lba_chs_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "lba_chs_address_translator_unit_assert.svh"

module lba_chs_checker
    import lba_chs_pkg::*;
#(
    parameter int LBA_BITS = 24
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_m_tvalid,
    input logic                                  i_m_tready,
    // tdata, low bit up: linear_sector_out, cylinder_out, head_out, sector_out, zero fill.
    input logic [((LBA_BITS+CHS_W+7)/8)*8-1:0]   i_m_tdata,
    // tuser: range_error.
    input logic                                  i_m_tuser
);

    logic [LBA_BITS-1:0] w_lba;
    logic [CYL_W-1:0]    w_cyl;
    logic [HEAD_W-1:0]   w_head;
    logic [SEC_W-1:0]    w_sec;

    assign w_lba  = i_m_tdata[LBA_BITS-1:0];
    assign w_cyl  = i_m_tdata[LBA_BITS +: CYL_W];
    assign w_head = i_m_tdata[LBA_BITS+CYL_W +: HEAD_W];
    assign w_sec  = i_m_tdata[LBA_BITS+CYL_W+HEAD_W +: SEC_W];

    // A result held back by the sink must stay put.
    `LCAT_ASSERT_NEXT(a_stall_holds, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "result item changed while stalled")

    // A range error clears every address field.
    `LCAT_ASSERT_SAME(a_err_zero, i_m_tvalid && i_m_tuser, i_m_tdata == '0, "flagged result item carries a nonzero address")

    // A good CHS result (sector is one-based, never zero) leaves the linear field clear.
    `LCAT_ASSERT_SAME(a_chs_only, i_m_tvalid && !i_m_tuser && (w_sec != '0), w_lba == '0, "CHS result item also carries a linear sector")

    // A good linear result leaves cylinder and head clear.
    `LCAT_ASSERT_SAME(a_lba_only, i_m_tvalid && !i_m_tuser && (w_sec == '0), (w_cyl == '0) && (w_head == '0), "linear result item also carries cylinder or head")

endmodule

bind lba_chs_address_translator_unit lba_chs_checker #(
    .LBA_BITS (LBA_BITS)
) u_lba_chs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
